FILE: rtl/core/rpwc_pkg.sv
`timescale 1ns / 1ps

package rpwc_pkg;

    // Fixed field widths of the sample and result beats
    localparam int PORT_FIELD_W  = 2;
    localparam int LEVELS_W      = 8;
    localparam int TIME_W        = 32;
    localparam int PIN_FIELD_W   = 3;
    localparam int KIND_W        = 3;
    localparam int CFG_INDEX_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACHED  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FREQ_ONLY = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_RISE      = 3'd0,
        KIND_PULSE     = 3'd1,
        KIND_FREQ      = 3'd2,
        KIND_FREQ_FALL = 3'd3,
        KIND_FALL_IGN  = 3'd4,
        KIND_UNATT     = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MOD
    } state_t;

    // One channel record as held in the record RAM
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] width_accum;
        logic [TIME_W-1:0] last_width;
        logic [TIME_W-1:0] edge_count;
        logic              alive;
    } rec_t;

    // Result of one channel update
    typedef struct packed {
        kind_t kind;
        logic  write;
        rec_t  rec;
    } upd_t;

endpackage

FILE: rtl/core/rpwc_in_if.sv
`timescale 1ns / 1ps

interface rpwc_in_if;
    logic                                valid;
    logic                                ready;
    logic [rpwc_pkg::PORT_FIELD_W-1:0]   port;
    logic [rpwc_pkg::LEVELS_W-1:0]       pin_levels;
    logic [rpwc_pkg::TIME_W-1:0]         now_us;

    modport source (output valid, output port, output pin_levels, output now_us,
                    input ready);
    modport sink (input valid, input port, input pin_levels, input now_us,
                  output ready);
endinterface

FILE: rtl/core/rpwc_out_if.sv
`timescale 1ns / 1ps

interface rpwc_out_if;
    logic                                valid;
    logic                                ready;
    logic [rpwc_pkg::PORT_FIELD_W-1:0]   port_index;
    logic [rpwc_pkg::PIN_FIELD_W-1:0]    pin_index;
    logic [rpwc_pkg::KIND_W-1:0]         event_kind;
    logic [rpwc_pkg::TIME_W-1:0]         pulse_width;
    logic [rpwc_pkg::TIME_W-1:0]         width_sum;
    logic [rpwc_pkg::TIME_W-1:0]         pulse_total;
    logic                                channel_alive;
    logic                                warn_flag;
    logic                                last;

    modport source (output valid, output port_index, output pin_index,
                    output event_kind, output pulse_width, output width_sum,
                    output pulse_total, output channel_alive, output warn_flag,
                    output last, input ready);
    modport sink (input valid, input port_index, input pin_index,
                  input event_kind, input pulse_width, input width_sum,
                  input pulse_total, input channel_alive, input warn_flag,
                  input last, output ready);
endinterface

FILE: rtl/core/rpwc_ram.sv
`timescale 1ns / 1ps

module rpwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/rpwc_upd.sv
`timescale 1ns / 1ps

module rpwc_upd (
    input  rpwc_pkg::rec_t                  rec,
    input  logic                            attached,
    input  logic                            freq_only,
    input  logic                            high,
    input  logic [rpwc_pkg::TIME_W-1:0]     now_us,
    output rpwc_pkg::upd_t                  upd
);

    logic [rpwc_pkg::TIME_W-1:0] width;

    assign width = now_us - rec.start_time;

    always_comb
    begin
        upd.rec   = rec;
        upd.write = 1'b0;
        upd.kind  = rpwc_pkg::KIND_FALL_IGN;
        if (!attached)
        begin
            upd.kind = rpwc_pkg::KIND_UNATT;
        end
        else if (freq_only)
        begin
            if (high)
            begin
                upd.rec.edge_count = rec.edge_count + rpwc_pkg::TIME_W'(1);
                upd.write          = 1'b1;
                upd.kind           = rpwc_pkg::KIND_FREQ;
            end
            else
            begin
                upd.kind = rpwc_pkg::KIND_FREQ_FALL;
            end
        end
        else if (high)
        begin
            upd.rec.start_time = now_us;
            upd.write          = 1'b1;
            upd.kind           = rpwc_pkg::KIND_RISE;
        end
        else if (rec.start_time != '0)
        begin
            // measured pulse: start time is kept for a repeated fall
            upd.rec.last_width  = width;
            upd.rec.width_accum = rec.width_accum + width;
            upd.rec.edge_count  = rec.edge_count + rpwc_pkg::TIME_W'(1);
            upd.rec.alive       = 1'b1;
            upd.write           = 1'b1;
            upd.kind            = rpwc_pkg::KIND_PULSE;
        end
    end

endmodule

FILE: rtl/core/rc_pulse_width_capture.sv
`timescale 1ns / 1ps

// RC pulse width capture.
// Sample channel: one beat carries a port number, the port's pin levels and
// a free-running microsecond time. Result channel: one beat for each enabled
// pin whose level changed, highest pin first; last marks the final beat of a
// sample. A sample with no enabled change only updates the stored levels;
// one on a port at or above PORTS is ignored. Neither gives a result.
// Configuration: cfg_we writes enable, attached or frequency-only masks
// (one bit per channel, channel = port * PINS_PER_PORT + pin). The user
// must write them only while idle; the block itself does not enforce it.
// Each handled pin is one read-modify-write of the channel record RAM: read
// issue in ST_READ, update and write back in ST_MOD. A new sample is taken
// only in ST_IDLE, once every handled pin of the last one is done.
// A registered result stage decouples the sides: a stalled receiver holds
// the engine only when a new result is ready and the stage is still full.
// Reset clears the masks, the stored levels, the warning flag and the
// per-channel valid bits; a record that was never written reads as zero.
module rc_pulse_width_capture #(
    parameter int PORTS         = 3,
    parameter int PINS_PER_PORT = 8
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [rpwc_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  logic [PORTS*PINS_PER_PORT-1:0]              cfg_data,
    rpwc_in_if.sink                                     sample,
    rpwc_out_if.source                                  result
);

    localparam int CHANNELS = PORTS * PINS_PER_PORT;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PIN_W    = (PINS_PER_PORT > 1) ? $clog2(PINS_PER_PORT) : 1;
    localparam int PSEL_W   = (PORTS > 1) ? $clog2(PORTS) : 1;

    // Configuration masks
    logic [CHANNELS-1:0] enable_reg;
    logic [CHANNELS-1:0] attached_reg;
    logic [CHANNELS-1:0] freq_only_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= '0;
            attached_reg  <= '0;
            freq_only_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rpwc_pkg::CFG_ENABLE:    enable_reg    <= cfg_data;
                rpwc_pkg::CFG_ATTACHED:  attached_reg  <= cfg_data;
                rpwc_pkg::CFG_FREQ_ONLY: freq_only_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Control state
    rpwc_pkg::state_t state_reg, state_next;

    logic [PINS_PER_PORT-1:0] prev_levels_reg [PORTS];
    logic [PINS_PER_PORT-1:0] pend_reg, pend_next;
    logic [PIN_W-1:0]         cur_pin_reg, cur_pin_next;
    logic [CHANNELS-1:0]      ch_valid_reg;
    logic                     warn_reg;
    logic                     out_valid_reg;

    // Sample payload held while its pins are handled
    logic [rpwc_pkg::PORT_FIELD_W-1:0] port_reg;
    logic [PINS_PER_PORT-1:0]          levels_reg;
    logic [rpwc_pkg::TIME_W-1:0]       now_reg;

    // Result stage payload
    logic [rpwc_pkg::PORT_FIELD_W-1:0] port_index_reg;
    logic [rpwc_pkg::PIN_FIELD_W-1:0]  pin_index_reg;
    logic [rpwc_pkg::KIND_W-1:0]       event_kind_reg;
    logic [rpwc_pkg::TIME_W-1:0]       pulse_width_reg;
    logic [rpwc_pkg::TIME_W-1:0]       width_sum_reg;
    logic [rpwc_pkg::TIME_W-1:0]       pulse_total_reg;
    logic                              channel_alive_reg;
    logic                              warn_flag_reg;
    logic                              last_reg;

    // Sample decode
    logic [PSEL_W-1:0]        in_sel;
    logic                     in_port_ok;
    logic [PINS_PER_PORT-1:0] in_levels;
    logic [PINS_PER_PORT-1:0] in_events;
    logic                     in_fire;

    assign in_sel     = PSEL_W'(sample.port);
    assign in_port_ok = int'(sample.port) < PORTS;
    assign in_levels  = sample.pin_levels[PINS_PER_PORT-1:0];
    assign in_events  = (in_levels ^ prev_levels_reg[in_sel]) &
                        enable_reg[in_sel * PINS_PER_PORT +: PINS_PER_PORT];
    assign in_fire    = sample.valid && sample.ready;

    // Highest pending pin
    logic [PIN_W-1:0] pick;

    always_comb
    begin
        pick = '0;
        for (int i = 0; i < PINS_PER_PORT; i++)
        begin
            if (pend_reg[i])
            begin
                pick = PIN_W'(i);
            end
        end
    end

    // Channel numbers for the read (picked pin) and the update (current pin)
    logic [PSEL_W-1:0] sel_reg;
    logic [CH_W-1:0]   rd_ch;
    logic [CH_W-1:0]   cur_ch;

    assign sel_reg = PSEL_W'(port_reg);
    assign rd_ch   = CH_W'(int'(sel_reg) * PINS_PER_PORT + int'(pick));
    assign cur_ch  = CH_W'(int'(sel_reg) * PINS_PER_PORT + int'(cur_pin_reg));

    // Record RAM and update
    logic           rd_en;
    logic           wr_en;
    logic           out_load;
    rpwc_pkg::rec_t ram_rd_data;
    rpwc_pkg::rec_t rec_cur;
    rpwc_pkg::upd_t upd;

    rpwc_ram #(
        .WIDTH ($bits(rpwc_pkg::rec_t)),
        .DEPTH (CHANNELS)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cur_ch),
        .wr_data (upd.rec),
        .rd_en   (rd_en),
        .rd_addr (rd_ch),
        .rd_data (ram_rd_data)
    );

    // A record never written reads as its reset value
    assign rec_cur = ch_valid_reg[cur_ch] ? ram_rd_data : rpwc_pkg::rec_t'('0);

    rpwc_upd u_upd (
        .rec       (rec_cur),
        .attached  (attached_reg[cur_ch]),
        .freq_only (freq_only_reg[cur_ch]),
        .high      (levels_reg[cur_pin_reg]),
        .now_us    (now_reg),
        .upd       (upd)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rpwc_pkg::ST_IDLE:
            begin
                if (in_fire && in_port_ok && (in_events != '0))
                begin
                    state_next = rpwc_pkg::ST_READ;
                end
            end
            rpwc_pkg::ST_READ:
            begin
                state_next = rpwc_pkg::ST_MOD;
            end
            rpwc_pkg::ST_MOD:
            begin
                if (out_load)
                begin
                    state_next = (pend_reg == '0) ? rpwc_pkg::ST_IDLE : rpwc_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = rpwc_pkg::ST_IDLE;
            end
        endcase
    end

    // Controls
    always_comb
    begin
        sample.ready = 1'b0;
        rd_en        = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            rpwc_pkg::ST_IDLE: sample.ready = 1'b1;
            rpwc_pkg::ST_READ: rd_en = 1'b1;
            rpwc_pkg::ST_MOD:  out_load = !out_valid_reg || result.ready;
            default:           ;
        endcase
    end

    assign wr_en = out_load && upd.write;

    // Drop the picked pin from the pending set as its read is issued
    always_comb
    begin
        pend_next    = pend_reg;
        cur_pin_next = cur_pin_reg;
        if (in_fire)
        begin
            pend_next = in_events;
        end
        else if (rd_en)
        begin
            cur_pin_next = pick;
            for (int i = 0; i < PINS_PER_PORT; i++)
            begin
                if (PIN_W'(i) == pick)
                begin
                    pend_next[i] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpwc_pkg::ST_IDLE;
            pend_reg      <= '0;
            cur_pin_reg   <= '0;
            ch_valid_reg  <= '0;
            warn_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < PORTS; p++)
            begin
                prev_levels_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            cur_pin_reg   <= cur_pin_next;
            out_valid_reg <= out_load || (out_valid_reg && !result.ready);
            if (in_fire && in_port_ok)
            begin
                prev_levels_reg[in_sel] <= in_levels;
            end
            if (wr_en)
            begin
                ch_valid_reg[cur_ch] <= 1'b1;
            end
            if (out_load && (upd.kind == rpwc_pkg::KIND_UNATT))
            begin
                warn_reg <= 1'b1;
            end
        end
    end

    // Payload registers: hold the sample, load the result stage
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            port_reg   <= sample.port;
            levels_reg <= in_levels;
            now_reg    <= sample.now_us;
        end
        if (out_load)
        begin
            port_index_reg <= port_reg;
            pin_index_reg  <= rpwc_pkg::PIN_FIELD_W'(cur_pin_reg);
            event_kind_reg <= upd.kind;
            last_reg       <= (pend_reg == '0);
            if (upd.kind == rpwc_pkg::KIND_UNATT)
            begin
                pulse_width_reg   <= '0;
                width_sum_reg     <= '0;
                pulse_total_reg   <= '0;
                channel_alive_reg <= 1'b0;
                warn_flag_reg     <= 1'b1;
            end
            else
            begin
                pulse_width_reg   <= upd.rec.last_width;
                width_sum_reg     <= upd.rec.width_accum;
                pulse_total_reg   <= upd.rec.edge_count;
                channel_alive_reg <= upd.rec.alive;
                warn_flag_reg     <= warn_reg;
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.port_index    = port_index_reg;
    assign result.pin_index     = pin_index_reg;
    assign result.event_kind    = event_kind_reg;
    assign result.pulse_width   = pulse_width_reg;
    assign result.width_sum     = width_sum_reg;
    assign result.pulse_total   = pulse_total_reg;
    assign result.channel_alive = channel_alive_reg;
    assign result.warn_flag     = warn_flag_reg;
    assign result.last          = last_reg;

    // A RAM read is always followed by its update cycle
    a_read_then_mod: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == rpwc_pkg::ST_MOD))
        else $error("record read not followed by update");

    // Only attached channels have their record written
    a_write_attached: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> attached_reg[cur_ch])
        else $error("record written for unattached channel");

    // A loaded result is presented on the next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("result stage load lost");

    // Ending a sample requires that the last result was marked last
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (pend_reg == '0)) |=> (last_reg && (state_reg == rpwc_pkg::ST_IDLE)))
        else $error("sample end not marked last");

endmodule

FILE: verif/rc_pulse_width_capture_test.sv
`timescale 1ns / 1ps

module rc_pulse_width_capture_test;
    import rpwc_pkg::*;

    localparam int N_PORTS        = 3;
    localparam int PINS           = 8;
    localparam int CHANNELS       = N_PORTS * PINS;
    localparam int RANDOM_ITEMS   = 460;
    localparam int PHASES         = 5;
    // Longest sample handles all eight pins in the engine; leave margin on top.
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int PRINT_LIMIT    = 40;
    localparam logic [CHANNELS-1:0] ALL_CH = '1;

    // One result beat as the receiver sees it
    typedef struct packed {
        logic [PORT_FIELD_W-1:0] port;
        logic [PIN_FIELD_W-1:0]  pin;
        kind_t                   kind;
        logic [TIME_W-1:0]       width;
        logic [TIME_W-1:0]       sum;
        logic [TIME_W-1:0]       total;
        logic                    alive;
        logic                    warn;
        logic                    last;
    } capture_beat_t;

    // Mirror of the channel records plus the queue of beats still owed by the block
    class capture_scoreboard;
        logic [CHANNELS-1:0] enable_bits;
        logic [CHANNELS-1:0] attach_bits;
        logic [CHANNELS-1:0] freq_bits;
        logic [LEVELS_W-1:0] levels_seen [N_PORTS];
        logic [TIME_W-1:0]   rise_time [CHANNELS];
        logic [TIME_W-1:0]   width_total [CHANNELS];
        logic [TIME_W-1:0]   width_last [CHANNELS];
        logic [TIME_W-1:0]   pulse_count [CHANNELS];
        logic                alive [CHANNELS];
        logic                warn;
        capture_beat_t       expected_events [$];
        int                  mismatches;
        int                  checked;
        int                  kind_hits [6];

        function new();
            enable_bits = '0;
            attach_bits = '0;
            freq_bits   = '0;
            foreach (levels_seen[i]) levels_seen[i] = '0;
            foreach (rise_time[c])
            begin
                rise_time[c]   = '0;
                width_total[c] = '0;
                width_last[c]  = '0;
                pulse_count[c] = '0;
                alive[c]       = 1'b0;
            end
            warn       = 1'b0;
            mismatches = 0;
            checked    = 0;
            foreach (kind_hits[k]) kind_hits[k] = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CHANNELS-1:0] data);
            case (index)
                CFG_ENABLE:    enable_bits = data;
                CFG_ATTACHED:  attach_bits = data;
                CFG_FREQ_ONLY: freq_bits   = data;
                default: ;
            endcase
        endfunction

        // Work out the beats one accepted sample causes, highest pin first.
        function void note_sample(logic [PORT_FIELD_W-1:0] port_sel,
                                  logic [LEVELS_W-1:0] levels,
                                  logic [TIME_W-1:0] stamp);
            logic [LEVELS_W-1:0] changed;
            logic [TIME_W-1:0]   span;
            capture_beat_t       beat;
            capture_beat_t       batch [$];
            int                  p;
            int                  c;
            if (port_sel >= N_PORTS)
                return;
            p = port_sel;
            changed = (levels ^ levels_seen[p]) & enable_bits[p * PINS +: PINS];
            levels_seen[p] = levels;
            for (int pin = PINS - 1; pin >= 0; pin--)
            begin
                if (!changed[pin])
                    continue;
                c = p * PINS + pin;
                beat = '0;
                beat.port = port_sel;
                beat.pin = PIN_FIELD_W'(pin);
                if (!attach_bits[c])
                begin
                    warn = 1'b1;
                    beat.kind = KIND_UNATT;
                end
                else if (freq_bits[c])
                begin
                    if (levels[pin])
                    begin
                        pulse_count[c] += 1;
                        beat.kind = KIND_FREQ;
                    end
                    else
                        beat.kind = KIND_FREQ_FALL;
                end
                else if (levels[pin])
                begin
                    rise_time[c] = stamp;
                    beat.kind = KIND_RISE;
                end
                else if (rise_time[c] != '0)
                begin
                    span = stamp - rise_time[c];
                    width_total[c] += span;
                    width_last[c] = span;
                    pulse_count[c] += 1;
                    alive[c] = 1'b1;
                    beat.kind = KIND_PULSE;
                end
                else
                    beat.kind = KIND_FALL_IGN;
                if (beat.kind != KIND_UNATT)
                begin
                    beat.width = width_last[c];
                    beat.sum   = width_total[c];
                    beat.total = pulse_count[c];
                    beat.alive = alive[c];
                end
                beat.warn = warn;
                batch.push_back(beat);
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i]) expected_events.push_back(batch[i]);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t ns mismatch: %s", $time, msg);
        endtask

        task check_event(capture_beat_t got);
            capture_beat_t want;
            string         tag;
            if (expected_events.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat, port %0d pin %0d kind %0d",
                                          got.port, got.pin, got.kind));
                return;
            end
            want = expected_events.pop_front();
            checked++;
            kind_hits[want.kind]++;
            tag = $sformatf("port %0d pin %0d", want.port, want.pin);
            if (got.port !== want.port)
                report_mismatch($sformatf("%s: port_index %0d", tag, got.port));
            if (got.pin !== want.pin)
                report_mismatch($sformatf("%s: pin_index %0d", tag, got.pin));
            if (got.kind !== want.kind)
                report_mismatch($sformatf("%s: event_kind %0d, want %0d", tag,
                                          got.kind, want.kind));
            if (got.width !== want.width)
                report_mismatch($sformatf("%s: pulse_width %0h, want %0h", tag,
                                          got.width, want.width));
            if (got.sum !== want.sum)
                report_mismatch($sformatf("%s: width_sum %0h, want %0h", tag,
                                          got.sum, want.sum));
            if (got.total !== want.total)
                report_mismatch($sformatf("%s: pulse_total %0h, want %0h", tag,
                                          got.total, want.total));
            if (got.alive !== want.alive)
                report_mismatch($sformatf("%s: channel_alive %b, want %b", tag,
                                          got.alive, want.alive));
            if (got.warn !== want.warn)
                report_mismatch($sformatf("%s: warn_flag %b, want %b", tag,
                                          got.warn, want.warn));
            if (got.last !== want.last)
                report_mismatch($sformatf("%s: last %b, want %b", tag,
                                          got.last, want.last));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CHANNELS-1:0]    cfg_data;

    rpwc_in_if  sample_bus ();
    rpwc_out_if result_bus ();

    rc_pulse_width_capture dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_bus),
        .result    (result_bus)
    );

    capture_scoreboard board = new();

    // Percent chance per cycle that either side sits out; zero means full rate.
    int idle_pct = 20;
    // Set by the stimulus to make the receiver hold off for that many cycles.
    int holdoff_req = 0;
    int cycle_count = 0;
    int samples_sent = 0;
    int settings_used = 0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Watchdog: give up well past the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("watchdog expired after %0d cycles, %0d beats still owed",
                     cycle_count, board.expected_events.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: check every accepted beat, then pick ready for the next edge.
    // Handshake signals are read at the edge, so they carry pre-edge values.
    initial
    begin
        int            hold;
        capture_beat_t seen;
        hold = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            begin
                seen.port  = result_bus.port_index;
                seen.pin   = result_bus.pin_index;
                seen.kind  = kind_t'(result_bus.event_kind);
                seen.width = result_bus.pulse_width;
                seen.sum   = result_bus.width_sum;
                seen.total = result_bus.pulse_total;
                seen.alive = result_bus.channel_alive;
                seen.warn  = result_bus.warn_flag;
                seen.last  = result_bus.last;
                board.check_event(seen);
            end
            // Latch a hold-off request and keep ready low for its whole length.
            if (holdoff_req > 0)
            begin
                hold = holdoff_req;
                holdoff_req = 0;
            end
            if (hold > 0)
            begin
                hold--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Offer one sample beat, idling first at random, and hold it until taken.
    // Valid stays high into the next call when no idle cycle falls in between.
    task automatic send_sample(input logic [PORT_FIELD_W-1:0] port_sel,
                               input logic [LEVELS_W-1:0] levels,
                               input logic [TIME_W-1:0] stamp);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid      <= 1'b1;
        sample_bus.port       <= port_sel;
        sample_bus.pin_levels <= levels;
        sample_bus.now_us     <= stamp;
        do
            @(posedge clk);
        while (sample_bus.ready !== 1'b1);
        board.note_sample(port_sel, levels, stamp);
        samples_sent++;
    endtask

    // Drop valid, wait for every owed beat, then let the engine finish any
    // sample that produced nothing.
    task automatic wait_idle();
        sample_bus.valid <= 1'b0;
        while (board.expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CHANNELS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.write_register(index, data);
        @(posedge clk);
    endtask

    task automatic configure(input logic [CHANNELS-1:0] enable_val,
                             input logic [CHANNELS-1:0] attach_val,
                             input logic [CHANNELS-1:0] freq_val);
        write_register(CFG_ENABLE, enable_val);
        write_register(CFG_ATTACHED, attach_val);
        write_register(CFG_FREQ_ONLY, freq_val);
        settings_used++;
    endtask

    initial
    begin
        int                      sent;
        logic [PORT_FIELD_W-1:0] port_sel;
        logic [LEVELS_W-1:0]     flip;
        logic [LEVELS_W-1:0]     levels;
        logic [TIME_W-1:0]       stamp;
        logic [TIME_W-1:0]       now_base;

        // Hold every input at a known value from time zero.
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= CFG_ENABLE;
        cfg_data              <= '0;
        sample_bus.valid      <= 1'b0;
        sample_bus.port       <= '0;
        sample_bus.pin_levels <= '0;
        sample_bus.now_us     <= '0;
        now_base = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- Directed part ---
        // Nothing watched: the levels are stored but no beat comes out.
        configure('0, '0, '0);
        send_sample(2'd0, 8'hFF, 32'd100);
        wait_idle();

        // Port 2 pin 7 unattached, port 1 pins 4..7 count rising edges only.
        configure(ALL_CH, 24'h7F_FFFF, 24'h00_F000);
        send_sample(2'd0, 8'h00, 32'd200);          // eight falls, no start yet
        send_sample(2'd0, 8'h81, 32'd0);            // rises stamped at time zero
        send_sample(2'd0, 8'h00, 32'd500);          // so these falls are ignored
        send_sample(2'd0, 8'hFF, 32'd1000);
        send_sample(2'd0, 8'h00, 32'd2500);         // eight full pulses
        send_sample(2'd1, 8'h0F, 32'hFFFF_FF00);
        send_sample(2'd1, 8'h00, 32'h0000_0100);    // width across the time wrap
        send_sample(2'd1, 8'hFF, 32'd5000);         // frequency counts plus rises
        send_sample(2'd1, 8'h00, 32'd6000);         // frequency falls plus pulses
        send_sample(2'd0, 8'h00, 32'd6500);         // no change at all
        send_sample(2'd3, 8'hFF, 32'd7000);         // port out of range
        send_sample(2'd2, 8'h80, 32'd8000);         // unattached pin raises warning
        send_sample(2'd2, 8'h81, 32'd8100);
        send_sample(2'd2, 8'h00, 32'd9000);
        send_sample(2'd0, 8'hFF, 32'hFFFF_FFFF);
        send_sample(2'd0, 8'h55, 32'h0000_0010);
        send_sample(2'd2, 8'hFF, 32'h8000_0000);
        send_sample(2'd2, 8'h00, 32'h8000_1234);
        wait_idle();

        // Toggle port 0 unwatched, then fall watched: the old start times are kept.
        write_register(CFG_ENABLE, 24'hFF_FF00);
        send_sample(2'd0, 8'hFF, 32'd20000);
        wait_idle();
        write_register(CFG_ENABLE, ALL_CH);
        send_sample(2'd0, 8'h00, 32'd21000);
        wait_idle();

        // --- Random part: one mask setting per phase ---
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: configure(ALL_CH, ALL_CH, '0);
                1: configure(ALL_CH, ALL_CH, ALL_CH);
                2: configure(CHANNELS'($urandom), CHANNELS'($urandom), CHANNELS'($urandom));
                3: configure(ALL_CH, '0, '0);
                default: configure(CHANNELS'($urandom), ALL_CH, CHANNELS'($urandom));
            endcase
            // First phase runs at full rate on both sides.
            idle_pct = (phase == 0) ? 0 : 20;
            // Starve the receiver so the result stage and engine back up.
            if (phase == 1 || phase == 4)
                holdoff_req = HOLDOFF_CYCLES;
            // Run the time base through its wrap.
            if (phase == 2)
                now_base = 32'hFFFF_0000;
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES)
            begin
                if ($urandom_range(99) < 15)
                begin
                    // Noise: any port, any levels, any time.
                    port_sel = PORT_FIELD_W'($urandom_range(3));
                    levels   = LEVELS_W'($urandom);
                    stamp    = $urandom;
                end
                else
                begin
                    // Well-formed: flip a few pins with time moving forward,
                    // so rises pair with later falls.
                    port_sel = PORT_FIELD_W'($urandom_range(N_PORTS - 1));
                    if ($urandom_range(1))
                        flip = LEVELS_W'(1) << $urandom_range(PINS - 1);
                    else
                        flip = LEVELS_W'($urandom) & LEVELS_W'($urandom);
                    now_base += $urandom_range(2500, 20);
                    stamp  = now_base;
                    levels = board.levels_seen[port_sel] ^ flip;
                end
                send_sample(port_sel, levels, stamp);
                if (port_sel < N_PORTS)
                    sent++;
            end
            wait_idle();
        end

        $display("covered %0d samples and %0d result beats over %0d mask settings, %0d cycles",
                 samples_sent, board.checked, settings_used, cycle_count);
        $display("kinds: rise %0d, pulse %0d, freq %0d, freq fall %0d, ignored fall %0d, unattached %0d",
                 board.kind_hits[KIND_RISE], board.kind_hits[KIND_PULSE],
                 board.kind_hits[KIND_FREQ], board.kind_hits[KIND_FREQ_FALL],
                 board.kind_hits[KIND_FALL_IGN], board.kind_hits[KIND_UNATT]);
        if (board.mismatches == 0 && board.expected_events.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
